### src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Command codes, status codes and the classified command record that the
// front end hands to the back end of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int ILS_DEPTH       = 64;
   localparam int ILS_QUEUE_DEPTH = 2;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_AT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // what the back end has to carry out
   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_INS_FRONT,
      OP_INS_BACK,
      OP_INS_AT,
      OP_DELETE
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [STAT_W-1:0]       status;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

### src/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of up to DEPTH signed 32-bit values with positional read,
// insert and delete commands, one result per command.
// ----------------------------------------------------------------------------
// usage: drive req_command, req_position and req_new_value with start high;
// the command is taken at the edge where start is high and busy is low.
// the front end classifies it against its own copy of the list length and
// queues it; busy is high only while that queue is full.
// every command gives exactly one result beat: rsp_valid is high for one
// cycle with rsp_read_value, rsp_status and rsp_list_length (length after
// the command). the receiver cannot stall; results come in command order.
// refused or ignored commands, inserts at the end and deletes of the last
// entry move no entries; other inserts and deletes shift the entries from
// the position to the end. the back end takes one command from the queue
// at a time and moves one entry per cycle through the RAM (one read and
// one write port).
// reset empties the list and the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_core
   import ils_pkg::*;
#(
   parameter int DEPTH       = ILS_DEPTH,
   parameter int QUEUE_DEPTH = ILS_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_new_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [LEN_W-1:0]        rsp_list_length
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   head_type  head;

   assign busy = queue_full;

   ils_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .queue_full    (queue_full),
      .req_command   (req_command),
      .req_position  (req_position),
      .req_new_value (req_new_value),
      .push          (push),
      .push_entry    (push_entry)
   );

   ils_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head       (head)
   );

   ils_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_list_length (rsp_list_length)
   );

endmodule

### src/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ils_front.sv
// ----------------------------------------------------------------------------
// ils_front
// Accepts commands, keeps a shadow of the list length and classifies each
// command into an operation and a final status before it is queued.
// ----------------------------------------------------------------------------
module ils_front
   import ils_pkg::*;
#(
   parameter int DEPTH = ILS_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     queue_full,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VAL_W-1:0]  req_new_value,
   output logic                     push,
   output entry_type                push_entry
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] pos_x, cnt_x;
   logic          full;

   assign push  = start && !queue_full;
   assign pos_x = LW'(req_position);
   assign cnt_x = LW'(count_ff);
   assign full  = (count_ff == CW'(DEPTH));

   always_comb begin
      push_entry.op       = OP_NONE;
      push_entry.status   = ST_DONE;
      push_entry.position = req_position;
      push_entry.value    = req_new_value;
      count_in            = count_ff;
      unique case (req_command)
         CMD_READ: begin
            if (pos_x < cnt_x) begin
               push_entry.op = OP_READ;
            end else begin
               push_entry.status = ST_RANGE;
            end
         end
         CMD_ADD_FRONT, CMD_ADD_BACK: begin
            if (full) begin
               push_entry.status = ST_FULL;
            end else begin
               push_entry.op = (req_command == CMD_ADD_FRONT) ? OP_INS_FRONT : OP_INS_BACK;
               count_in      = count_ff + 1'b1;
            end
         end
         CMD_ADD_AT: begin
            // range is checked before fullness
            if (pos_x > cnt_x) begin
               push_entry.status = ST_RANGE;
            end else if (full) begin
               push_entry.status = ST_FULL;
            end else begin
               push_entry.op = OP_INS_AT;
               count_in      = count_ff + 1'b1;
            end
         end
         CMD_DELETE: begin
            if (pos_x < cnt_x) begin
               push_entry.op = OP_DELETE;
               count_in      = count_ff - 1'b1;
            end else begin
               push_entry.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_in;
      end
   end

endmodule

### src/ils_queue.sv
// ----------------------------------------------------------------------------
// ils_queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module ils_queue
   import ils_pkg::*;
#(
   parameter int QUEUE_DEPTH = ILS_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output head_type  head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   entry_type     slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;

   assign full       = (fill_ff == FW'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

endmodule

### src/ils_back.sv
// ----------------------------------------------------------------------------
// ils_back
// Carries out classified commands on the list held in RAM: reads, shifts
// entries up for inserts and down for deletes, and issues one result each.
// ----------------------------------------------------------------------------
module ils_back
   import ils_pkg::*;
#(
   parameter int DEPTH = ILS_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  head_type                head,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [LEN_W-1:0]        rsp_list_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_INS,
      S_INS_LAST,
      S_DEL
   } state_type;

   state_type                state_ff, state_in;
   entry_type                cur_ff, cur_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            src_ff, src_in;
   logic [CW-1:0]            tgt_ff, tgt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]         rsp_list_length_ff, rsp_list_length_in;

   logic [LW-1:0]            pos_x;
   logic [CW-1:0]            pos_c;
   logic [CW-1:0]            tgt_c;
   logic [LW-1:0]            len_x;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [VAL_W-1:0]         wr_data, rd_data;

   ils_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // position is in range whenever it is used, so it fits the count width
   assign pos_x = LW'(cur_ff.position);
   assign pos_c = pos_x[CW-1:0];
   assign len_x = LW'(count_in);

   always_comb begin
      unique case (cur_ff.op)
         OP_INS_FRONT: tgt_c = '0;
         OP_INS_BACK:  tgt_c = count_ff;
         default:      tgt_c = pos_c;
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      cur_in             = cur_ff;
      count_in           = count_ff;
      src_in             = src_ff;
      tgt_in             = tgt_ff;
      rsp_valid_in       = 1'b0;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_status_in      = rsp_status_ff;
      pop                = 1'b0;
      wr_en              = 1'b0;
      wr_addr            = '0;
      wr_data            = cur_ff.value;
      rd_en              = 1'b0;
      rd_addr            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cur_in   = head.entry;
               state_in = S_START;
            end
         end
         S_START: begin
            rsp_read_value_in = '0;
            rsp_status_in     = cur_ff.status;
            tgt_in            = tgt_c;
            unique case (cur_ff.op)
               OP_READ: begin
                  rd_en    = 1'b1;
                  rd_addr  = pos_c[AW-1:0];
                  state_in = S_READ;
               end
               OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                  if (count_ff == tgt_c) begin
                     wr_en        = 1'b1;
                     wr_addr      = tgt_c[AW-1:0];
                     count_in     = count_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     src_in   = count_ff - 1'b1;
                     rd_addr  = src_in[AW-1:0];
                     state_in = S_INS;
                  end
               end
               OP_DELETE: begin
                  if (pos_c == count_ff - 1'b1) begin
                     count_in     = count_ff - 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     src_in   = pos_c + 1'b1;
                     rd_addr  = src_in[AW-1:0];
                     state_in = S_DEL;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            rsp_read_value_in = rd_data;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         S_INS: begin
            // move entry src up by one, walking down toward the target
            wr_en   = 1'b1;
            src_in  = src_ff + 1'b1;
            wr_addr = src_in[AW-1:0];
            wr_data = rd_data;
            if (src_ff == tgt_ff) begin
               src_in   = src_ff;
               state_in = S_INS_LAST;
            end else begin
               rd_en   = 1'b1;
               src_in  = src_ff - 1'b1;
               rd_addr = src_in[AW-1:0];
            end
         end
         S_INS_LAST: begin
            wr_en        = 1'b1;
            wr_addr      = tgt_ff[AW-1:0];
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DEL: begin
            // move entry src down by one, walking up toward the end
            wr_en   = 1'b1;
            src_in  = src_ff - 1'b1;
            wr_addr = src_in[AW-1:0];
            wr_data = rd_data;
            if (src_ff == count_ff - 1'b1) begin
               src_in       = src_ff;
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               src_in  = src_ff + 1'b1;
               rd_addr = src_in[AW-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_list_length_in = rsp_valid_in ? len_x[LEN_W-1:0] : rsp_list_length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff             <= cur_in;
      src_ff             <= src_in;
      tgt_ff             <= tgt_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_list_length_ff <= rsp_list_length_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_list_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list length beyond depth");

   a_one_result_per_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("results issued in consecutive cycles");

   a_ins_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS |-> src_ff >= tgt_ff && src_ff < count_ff)
      else $error("insert shift walked outside the list");

   a_del_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEL |-> src_ff < count_ff && src_ff != '0)
      else $error("delete shift walked outside the list");

endmodule
